>>> hw/rtl/lsc_pkg.sv
// ============================================================================
// lsc_pkg
// Shared types and constants of the line segment clipper: register indexes,
// result destinations, divider control word and sequencer states.
// ============================================================================
package lsc_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int MAX_PASSES_DEF  = 4;
  localparam int TOL_WIDTH       = 16;
  localparam int CFG_IDX_WIDTH   = 3;
  localparam int WIN_RESET_MAG   = 65536;
  localparam int TOL_RESET       = 7;

  // outcode bit positions
  localparam int OC_LEFT   = 0;
  localparam int OC_RIGHT  = 1;
  localparam int OC_BOTTOM = 2;
  localparam int OC_TOP    = 3;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    REG_CLIP_MODE  = 3'd0,
    REG_WIN_X_MIN  = 3'd1,
    REG_WIN_X_MAX  = 3'd2,
    REG_WIN_Y_MIN  = 3'd3,
    REG_WIN_Y_MAX  = 3'd4,
    REG_EDGE_TOL   = 3'd5
  } lsc_reg_e;

  // which endpoint coordinate a quotient lands in
  typedef enum logic [1:0] {
    DEST_SX = 2'd0,
    DEST_SY = 2'd1,
    DEST_EX = 2'd2,
    DEST_EY = 2'd3
  } lsc_dest_e;

  typedef struct packed {
    logic      valid;
    logic      ovf;
    logic      neg;
    lsc_dest_e dest;
  } lsc_ctl_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LB_EDGE,
    ST_LB_MUL2,
    ST_LB_CMP,
    ST_LB_FIN0,
    ST_LB_FIN1,
    ST_LB_FIN2,
    ST_LB_JOB,
    ST_DIV_WAIT,
    ST_CS_TEST,
    ST_CS_WAIT,
    ST_DONE
  } lsc_state_e;

endpackage

>>> hw/rtl/line_segment_clipper_core.sv
// ============================================================================
// line_segment_clipper_core
// Clips one 2-D segment against a configured window, by Liang-Barsky or by
// Cohen-Sutherland, and returns a visible flag with the clipped endpoints.
// ============================================================================
//
//  channel   direction  handshake                payload
//  s_axis    in         tvalid/tready            tdata: start_x, start_y, end_x, end_y
//  m_axis    out        tvalid/tready            tdata: clip ends; tuser: visible
//  cfg       in         we (no wait)             index, wdata
//
//  One segment is in work at a time; tready is high only while the sequencer
//  is idle. Every quotient runs through the divider chain, one cell per
//  quotient bit (COORD_WIDTH+1 cells), and then the registered add of the
//  base with saturation. Liang-Barsky: edge tests, then up to 4 quotients
//  issued back to back into the chain, overlapped. Cohen-Sutherland: one
//  chain pass per endpoint move, up to MAX_PASSES moves. A result waits in
//  the output register; the next segment is taken while it waits, but
//  finishes only once the register is free. Reset (async, active low) clears
//  control state and loads the reset window; no clearing pass.
//
module line_segment_clipper_core #(
  parameter int COORD_WIDTH = lsc_pkg::COORD_WIDTH_DEF,
  parameter int MAX_PASSES  = lsc_pkg::MAX_PASSES_DEF
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  // configuration write port
  input  logic                                       cfg_we_i,
  input  logic [lsc_pkg::CFG_IDX_WIDTH-1:0]          cfg_index_i,
  input  logic [COORD_WIDTH-1:0]                     cfg_wdata_i,
  // segment requests: start_x, start_y, end_x, end_y (lowest bits first)
  input  logic                                       s_axis_tvalid_i,
  output logic                                       s_axis_tready_o,
  input  logic [((4*COORD_WIDTH+7)/8)*8-1:0]         s_axis_tdata_i,
  // results: clip_start_x, clip_start_y, clip_end_x, clip_end_y (lowest first)
  output logic                                       m_axis_tvalid_o,
  input  logic                                       m_axis_tready_i,
  output logic [((4*COORD_WIDTH+7)/8)*8-1:0]         m_axis_tdata_o,
  // visible
  output logic [0:0]                                 m_axis_tuser_o
);
  import lsc_pkg::*;

  localparam int CW  = COORD_WIDTH;
  localparam int DW  = CW + 2;
  localparam int PW  = 2 * DW;
  localparam int TW  = ((4*CW+7)/8)*8;
  localparam int PCW = $clog2(MAX_PASSES + 1);
  localparam logic signed [CW-1:0] WIN_HI = CW'(WIN_RESET_MAG);
  localparam logic signed [CW-1:0] WIN_LO = CW'(-WIN_RESET_MAG);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic                         mode_q;
  logic signed [CW-1:0]         wxmin_q, wxmax_q, wymin_q, wymax_q;
  logic [TOL_WIDTH-1:0]         tol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= 1'b0;
      wxmin_q <= WIN_LO;
      wxmax_q <= WIN_HI;
      wymin_q <= WIN_LO;
      wymax_q <= WIN_HI;
      tol_q   <= TOL_WIDTH'(TOL_RESET);
    end else if (cfg_we_i) begin
      unique case (lsc_reg_e'(cfg_index_i))
        REG_CLIP_MODE: mode_q  <= cfg_wdata_i[0];
        REG_WIN_X_MIN: wxmin_q <= cfg_wdata_i;
        REG_WIN_X_MAX: wxmax_q <= cfg_wdata_i;
        REG_WIN_Y_MIN: wymin_q <= cfg_wdata_i;
        REG_WIN_Y_MAX: wymax_q <= cfg_wdata_i;
        REG_EDGE_TOL:  tol_q   <= cfg_wdata_i[TOL_WIDTH-1:0];
        default: ;  // ignore writes beyond the register list
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Working registers
  // --------------------------------------------------------------------------
  lsc_state_e                   state_q, state_d;
  logic signed [CW-1:0]         sx_q, sy_q, ex_q, ey_q;
  logic signed [DW-1:0]         dx_q, dy_q;
  logic signed [DW-1:0]         a1_q, b1_q, a2_q, b2_q;
  logic signed [DW-1:0]         n_q, d_q;
  logic                         pneg_q;
  logic [1:0]                   k_q, job_q;
  logic [PCW-1:0]               pass_q;
  logic                         vis_q;
  logic signed [PW-1:0]         prod_q, prodp_q;

  // divider issue stage: product sits in prod_q, the rest rides alongside
  lsc_ctl_t                     iss_q, iss_d;
  logic [DW-1:0]                iss_den_q, iss_den_d;
  logic signed [CW-1:0]         iss_base_q, iss_base_d;

  logic                         m_valid_q;
  logic                         out_vis_q;
  logic [4*CW-1:0]              out_data_q;

  logic                         s_hs;
  logic                         done_take;

  assign s_hs      = s_axis_tvalid_i && s_axis_tready_o;
  assign done_take = !m_valid_q || m_axis_tready_i;

  // --------------------------------------------------------------------------
  // Liang-Barsky edge terms
  // --------------------------------------------------------------------------
  logic signed [DW-1:0] lb_p, lb_q, lb_n, lb_d;

  always_comb begin
    unique case (k_q)
      2'd0: begin
        lb_p = -dx_q;
        lb_q = DW'(sx_q) - DW'(wxmin_q);
      end
      2'd1: begin
        lb_p = dx_q;
        lb_q = DW'(wxmax_q) - DW'(sx_q);
      end
      2'd2: begin
        lb_p = -dy_q;
        lb_q = DW'(sy_q) - DW'(wymin_q);
      end
      default: begin
        lb_p = dy_q;
        lb_q = DW'(wymax_q) - DW'(sy_q);
      end
    endcase
    lb_n = lb_p[DW-1] ? -lb_q : lb_q;
    lb_d = lb_p[DW-1] ? -lb_p : lb_p;
  end

  // --------------------------------------------------------------------------
  // Cohen-Sutherland outcodes, with tolerance widening the window
  // --------------------------------------------------------------------------
  logic signed [DW-1:0] tol_s, xlo, xhi, ylo, yhi;
  logic [3:0]           oc1, oc2, cs_out;
  logic                 cs_tb;
  logic signed [DW-1:0] cdx, cdy;

  function automatic logic [3:0] outcode(
    input logic signed [DW-1:0] x,
    input logic signed [DW-1:0] y,
    input logic signed [DW-1:0] x_lo,
    input logic signed [DW-1:0] x_hi,
    input logic signed [DW-1:0] y_lo,
    input logic signed [DW-1:0] y_hi
  );
    logic [3:0] c;
    c = '0;
    if (x < x_lo) begin
      c[OC_LEFT] = 1'b1;
    end else if (x > x_hi) begin
      c[OC_RIGHT] = 1'b1;
    end
    if (y < y_lo) begin
      c[OC_BOTTOM] = 1'b1;
    end else if (y > y_hi) begin
      c[OC_TOP] = 1'b1;
    end
    return c;
  endfunction

  always_comb begin
    tol_s  = signed'(DW'(tol_q));
    xlo    = DW'(wxmin_q) - tol_s;
    xhi    = DW'(wxmax_q) + tol_s;
    ylo    = DW'(wymin_q) - tol_s;
    yhi    = DW'(wymax_q) + tol_s;
    oc1    = outcode(DW'(sx_q), DW'(sy_q), xlo, xhi, ylo, yhi);
    oc2    = outcode(DW'(ex_q), DW'(ey_q), xlo, xhi, ylo, yhi);
    cs_out = (oc1 != '0) ? oc1 : oc2;
    cs_tb  = cs_out[OC_TOP] || cs_out[OC_BOTTOM];
    cdx    = DW'(ex_q) - DW'(sx_q);
    cdy    = DW'(ey_q) - DW'(sy_q);
  end

  // --------------------------------------------------------------------------
  // Multiplier: one product per cycle, registered
  // --------------------------------------------------------------------------
  logic signed [DW-1:0] mul_a, mul_b, jden;
  logic signed [PW-1:0] mul_p;
  logic                 reject, cs_accept, cs_go;

  assign mul_p = PW'(mul_a) * PW'(mul_b);

  // --------------------------------------------------------------------------
  // Divider chain
  // --------------------------------------------------------------------------
  lsc_ctl_t             div_ctl;
  logic signed [CW-1:0] div_value;
  logic                 div_busy;
  logic [PW-1:0]        prod_abs;

  assign prod_abs = prod_q[PW-1] ? PW'(-prod_q) : PW'(prod_q);

  lsc_divider #(
    .COORD_WIDTH(CW)
  ) u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_ctl_i    (iss_q),
    .in_num_i    (prod_abs),
    .in_den_i    (iss_den_q),
    .in_base_i   (iss_base_q),
    .out_ctl_o   (div_ctl),
    .out_value_o (div_value),
    .busy_o      (div_busy)
  );

  // --------------------------------------------------------------------------
  // Sequencer: next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_hs) begin
          state_d = mode_q ? ST_CS_TEST : ST_LB_EDGE;
        end
      end
      ST_LB_EDGE: begin
        if (reject) begin
          state_d = ST_DONE;
        end else if (lb_p == '0) begin
          state_d = (k_q == 2'd3) ? ST_LB_FIN0 : ST_LB_EDGE;
        end else begin
          state_d = ST_LB_MUL2;
        end
      end
      ST_LB_MUL2: state_d = ST_LB_CMP;
      ST_LB_CMP:  state_d = (k_q == 2'd3) ? ST_LB_FIN0 : ST_LB_EDGE;
      ST_LB_FIN0: state_d = ST_LB_FIN1;
      ST_LB_FIN1: state_d = ST_LB_FIN2;
      ST_LB_FIN2: state_d = reject ? ST_DONE : ST_LB_JOB;
      ST_LB_JOB: begin
        if (job_q == 2'd3) begin
          state_d = ST_DIV_WAIT;
        end
      end
      ST_DIV_WAIT: begin
        if (!iss_q.valid && !div_busy) begin
          state_d = ST_DONE;
        end
      end
      ST_CS_TEST: begin
        if (cs_accept || reject) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_CS_WAIT;
        end
      end
      ST_CS_WAIT: begin
        if (!iss_q.valid && !div_busy) begin
          state_d = ST_CS_TEST;
        end
      end
      ST_DONE: begin
        if (done_take) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer: multiplier operands, divider issue, decisions
  // --------------------------------------------------------------------------
  always_comb begin
    mul_a      = '0;
    mul_b      = '0;
    jden       = DW'(1);
    iss_d      = '0;
    iss_base_d = '0;
    reject     = 1'b0;
    cs_accept  = 1'b0;
    cs_go      = 1'b0;
    unique case (state_q)
      ST_LB_EDGE: begin
        if (lb_p == '0) begin
          reject = lb_q[DW-1];
        end else if (lb_p[DW-1]) begin
          mul_a = lb_n;
          mul_b = b1_q;
        end else begin
          mul_a = a2_q;
          mul_b = lb_d;
        end
      end
      ST_LB_MUL2: begin
        if (pneg_q) begin
          mul_a = a1_q;
          mul_b = d_q;
        end else begin
          mul_a = n_q;
          mul_b = b2_q;
        end
      end
      ST_LB_FIN0: begin
        mul_a = a1_q;
        mul_b = b2_q;
      end
      ST_LB_FIN1: begin
        mul_a = a2_q;
        mul_b = b1_q;
      end
      ST_LB_FIN2: begin
        reject = prodp_q > prod_q;
      end
      ST_LB_JOB: begin
        // end point from u2 first, then start point from u1
        unique case (job_q)
          2'd0: begin
            mul_a = dx_q; mul_b = a2_q; jden = b2_q;
            iss_base_d = sx_q; iss_d.dest = DEST_EX; iss_d.valid = a2_q < b2_q;
          end
          2'd1: begin
            mul_a = dy_q; mul_b = a2_q; jden = b2_q;
            iss_base_d = sy_q; iss_d.dest = DEST_EY; iss_d.valid = a2_q < b2_q;
          end
          2'd2: begin
            mul_a = dx_q; mul_b = a1_q; jden = b1_q;
            iss_base_d = sx_q; iss_d.dest = DEST_SX; iss_d.valid = a1_q > '0;
          end
          default: begin
            mul_a = dy_q; mul_b = a1_q; jden = b1_q;
            iss_base_d = sy_q; iss_d.dest = DEST_SY; iss_d.valid = a1_q > '0;
          end
        endcase
      end
      ST_CS_TEST: begin
        if ((oc1 | oc2) == '0) begin
          cs_accept = 1'b1;
        end else if ((oc1 & oc2) != '0) begin
          reject = 1'b1;
        end else if (pass_q == PCW'(MAX_PASSES)) begin
          reject = 1'b1;
        end else if (cs_tb ? (cdy == '0) : (cdx == '0)) begin
          reject = 1'b1;
        end else begin
          cs_go       = 1'b1;
          iss_d.valid = 1'b1;
          if (cs_tb) begin
            mul_a      = cdx;
            mul_b      = (cs_out[OC_TOP] ? DW'(wymax_q) : DW'(wymin_q)) - DW'(sy_q);
            jden       = cdy;
            iss_base_d = sx_q;
            iss_d.dest = (oc1 != '0) ? DEST_SX : DEST_EX;
          end else begin
            mul_a      = cdy;
            mul_b      = (cs_out[OC_RIGHT] ? DW'(wxmax_q) : DW'(wxmin_q)) - DW'(sx_q);
            jden       = cdx;
            iss_base_d = sy_q;
            iss_d.dest = (oc1 != '0) ? DEST_SY : DEST_EY;
          end
        end
      end
      default: ;
    endcase
    iss_d.neg = mul_a[DW-1] ^ mul_b[DW-1] ^ jden[DW-1];
    iss_den_d = jden[DW-1] ? DW'(-jden) : DW'(jden);
  end

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      iss_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      iss_q   <= iss_d;
      if (state_q == ST_DONE && done_take) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Datapath registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    prod_q     <= mul_p;
    prodp_q    <= prod_q;
    iss_den_q  <= iss_den_d;
    iss_base_q <= iss_base_d;

    if (reject) begin
      vis_q <= 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (s_hs) begin
          // take the segment, start u1 = 0/1 and u2 = 1/1
          sx_q   <= s_axis_tdata_i[0*CW +: CW];
          sy_q   <= s_axis_tdata_i[1*CW +: CW];
          ex_q   <= s_axis_tdata_i[2*CW +: CW];
          ey_q   <= s_axis_tdata_i[3*CW +: CW];
          dx_q   <= DW'(signed'(s_axis_tdata_i[2*CW +: CW]))
                    - DW'(signed'(s_axis_tdata_i[0*CW +: CW]));
          dy_q   <= DW'(signed'(s_axis_tdata_i[3*CW +: CW]))
                    - DW'(signed'(s_axis_tdata_i[1*CW +: CW]));
          a1_q   <= '0;
          b1_q   <= DW'(1);
          a2_q   <= DW'(1);
          b2_q   <= DW'(1);
          k_q    <= '0;
          job_q  <= '0;
          pass_q <= '0;
          vis_q  <= 1'b1;
        end
      end
      ST_LB_EDGE: begin
        n_q    <= lb_n;
        d_q    <= lb_d;
        pneg_q <= lb_p[DW-1];
        if (lb_p == '0) begin
          k_q <= k_q + 2'd1;
        end
      end
      ST_LB_CMP: begin
        // tighten u1 or u2 when this edge gives the stronger limit
        if (prodp_q > prod_q) begin
          if (pneg_q) begin
            a1_q <= n_q;
            b1_q <= d_q;
          end else begin
            a2_q <= n_q;
            b2_q <= d_q;
          end
        end
        k_q <= k_q + 2'd1;
      end
      ST_LB_JOB: begin
        job_q <= job_q + 2'd1;
      end
      ST_CS_TEST: begin
        // snap the moving endpoint onto the chosen edge now
        if (cs_go) begin
          pass_q <= pass_q + PCW'(1);
          if (cs_tb) begin
            if (oc1 != '0) begin
              sy_q <= cs_out[OC_TOP] ? wymax_q : wymin_q;
            end else begin
              ey_q <= cs_out[OC_TOP] ? wymax_q : wymin_q;
            end
          end else begin
            if (oc1 != '0) begin
              sx_q <= cs_out[OC_RIGHT] ? wxmax_q : wxmin_q;
            end else begin
              ex_q <= cs_out[OC_RIGHT] ? wxmax_q : wxmin_q;
            end
          end
        end
      end
      ST_DONE: begin
        if (done_take) begin
          out_vis_q  <= vis_q;
          out_data_q <= vis_q ? {ey_q, ex_q, sy_q, sx_q} : '0;
        end
      end
      default: ;
    endcase

    // quotient returns land in their endpoint coordinate
    if (div_ctl.valid) begin
      unique case (div_ctl.dest)
        DEST_SX: sx_q <= div_value;
        DEST_SY: sy_q <= div_value;
        DEST_EX: ex_q <= div_value;
        default: ey_q <= div_value;
      endcase
    end
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = TW'(out_data_q);
  assign m_axis_tuser_o  = out_vis_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
`ifndef ASSERT_OFF
  a_idle_chain_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> !div_busy)
    else $error("divider busy while a new segment can be taken");

  a_quot_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_ctl.valid |-> (state_q == ST_DIV_WAIT || state_q == ST_CS_WAIT))
    else $error("quotient returned outside a wait state");

  a_pass_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> (pass_q <= PCW'(MAX_PASSES)))
    else $error("endpoint moves beyond pass cap");

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && done_take && !vis_q) |=> (m_axis_tdata_o == '0))
    else $error("rejected segment with nonzero coordinates");
`endif

endmodule

>>> hw/rtl/lsc_div_cell.sv
// ============================================================================
// lsc_div_cell
// One restoring division step: shift in the next numerator bit, subtract the
// divisor when it fits, shift the quotient bit in, register and hand on.
// ============================================================================
module lsc_div_cell #(
  parameter int COORD_WIDTH = lsc_pkg::COORD_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  lsc_pkg::lsc_ctl_t              ctl_i,
  input  logic [COORD_WIDTH+1:0]         rem_i,
  input  logic [COORD_WIDTH:0]           sh_i,
  input  logic [COORD_WIDTH+1:0]         den_i,
  input  logic signed [COORD_WIDTH-1:0]  base_i,
  output lsc_pkg::lsc_ctl_t              ctl_o,
  output logic [COORD_WIDTH+1:0]         rem_o,
  output logic [COORD_WIDTH:0]           sh_o,
  output logic [COORD_WIDTH+1:0]         den_o,
  output logic signed [COORD_WIDTH-1:0]  base_o
);
  import lsc_pkg::*;

  localparam int DW = COORD_WIDTH + 2;
  localparam int QW = COORD_WIDTH + 1;

  lsc_ctl_t              ctl_q;
  logic [DW-1:0]         rem_q, rem_d;
  logic [QW-1:0]         sh_q, sh_d;
  logic [DW-1:0]         den_q;
  logic signed [COORD_WIDTH-1:0] base_q;
  logic [DW:0]           trial;
  logic                  fits;

  always_comb begin
    trial = {rem_i, sh_i[QW-1]};
    fits  = trial >= {1'b0, den_i};
    rem_d = fits ? DW'(trial - {1'b0, den_i}) : trial[DW-1:0];
    sh_d  = {sh_i[QW-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    sh_q   <= sh_d;
    den_q  <= den_i;
    base_q <= base_i;
  end

  assign ctl_o  = ctl_q;
  assign rem_o  = rem_q;
  assign sh_o   = sh_q;
  assign den_o  = den_q;
  assign base_o = base_q;

endmodule

>>> hw/rtl/lsc_divider.sv
// ============================================================================
// lsc_divider
// Chain of division cells, one quotient bit per cell, followed by the
// signed add of the base coordinate and saturation to the coordinate range.
// ============================================================================
module lsc_divider #(
  parameter int COORD_WIDTH = lsc_pkg::COORD_WIDTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  lsc_pkg::lsc_ctl_t                  in_ctl_i,
  input  logic [2*COORD_WIDTH+3:0]           in_num_i,
  input  logic [COORD_WIDTH+1:0]             in_den_i,
  input  logic signed [COORD_WIDTH-1:0]      in_base_i,
  output lsc_pkg::lsc_ctl_t                  out_ctl_o,
  output logic signed [COORD_WIDTH-1:0]      out_value_o,
  output logic                               busy_o
);
  import lsc_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int DW = CW + 2;
  localparam int QW = CW + 1;
  localparam int PW = 2 * DW;
  localparam int SW = CW + 3;
  localparam logic signed [SW-1:0] SAT_MAX = SW'({1'b0, {(CW-1){1'b1}}});
  localparam logic signed [SW-1:0] SAT_MIN = -SAT_MAX - SW'(1);

  lsc_ctl_t                ctl   [QW+1];
  logic [DW-1:0]           rem   [QW+1];
  logic [QW-1:0]           sh    [QW+1];
  logic [DW-1:0]           den   [QW+1];
  logic signed [CW-1:0]    base  [QW+1];
  logic [QW:0]             vld_vec;

  lsc_ctl_t                out_ctl_q;
  logic signed [CW-1:0]    out_value_q;
  logic [QW-1:0]           quot;
  logic signed [SW-1:0]    sum;
  logic signed [CW-1:0]    sat_value;

  // entry: a quotient that cannot fit flags overflow and saturates later
  always_comb begin
    ctl[0]       = in_ctl_i;
    ctl[0].ovf   = in_num_i[PW-1:QW] >= (PW-QW)'(in_den_i);
    rem[0]       = ctl[0].ovf ? '0 : in_num_i[QW+DW-1:QW];
    sh[0]        = in_num_i[QW-1:0];
    den[0]       = in_den_i;
    base[0]      = in_base_i;
  end

  for (genvar i = 0; i < QW; i++) begin : g_cell
    lsc_div_cell #(
      .COORD_WIDTH(CW)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl[i]),
      .rem_i  (rem[i]),
      .sh_i   (sh[i]),
      .den_i  (den[i]),
      .base_i (base[i]),
      .ctl_o  (ctl[i+1]),
      .rem_o  (rem[i+1]),
      .sh_o   (sh[i+1]),
      .den_o  (den[i+1]),
      .base_o (base[i+1])
    );
  end

  for (genvar i = 0; i <= QW; i++) begin : g_vld
    if (i == 0) begin : g_out
      assign vld_vec[i] = out_ctl_q.valid;
    end else begin : g_stage
      assign vld_vec[i] = ctl[i].valid;
    end
  end

  always_comb begin
    quot = ctl[QW].ovf ? '1 : sh[QW];
    sum  = SW'(base[QW]) + (ctl[QW].neg ? -SW'(quot) : SW'(quot));
    if (sum > SAT_MAX) begin
      sat_value = SAT_MAX[CW-1:0];
    end else if (sum < SAT_MIN) begin
      sat_value = SAT_MIN[CW-1:0];
    end else begin
      sat_value = sum[CW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ctl_q <= '0;
    end else begin
      out_ctl_q <= ctl[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    out_value_q <= sat_value;
  end

  assign out_ctl_o   = out_ctl_q;
  assign out_value_o = out_value_q;
  assign busy_o      = |vld_vec;

endmodule
